>>> design/assert_macros.svh
// ---------------------------------------------------------------------------
// assert_macros.svh
// Clocked assertion macros used by the detector design file.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// Check a property at every rising edge outside reset.
`define ASSERT_ALWAYS(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Check that a condition is followed by a consequence in the next cycle.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`else

`define ASSERT_ALWAYS(label, clk, rst_n, prop, msg)
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg)

`endif

`endif

>>> design/whvd_pkg.sv
// ---------------------------------------------------------------------------
// whvd_pkg
// Types and constants of the windowed vote hysteresis detector.
// ---------------------------------------------------------------------------
package whvd_pkg;

    localparam int TIME_W      = 40;
    localparam int SCORE_W     = 16;
    localparam int STATUS_W    = 3;
    localparam int REQ_W       = 4;
    localparam int COUNT_OUT_W = 4;
    localparam int CFG_IDX_W   = 3;
    localparam int CFG_DATA_W  = 16;

    typedef logic [STATUS_W-1:0]  status_t;
    typedef logic [CFG_IDX_W-1:0] cfg_idx_t;

    // Status codes of one result beat
    localparam status_t ST_PAUSED    = 3'd0;
    localparam status_t ST_QUIET     = 3'd1;
    localparam status_t ST_CANDIDATE = 3'd2;
    localparam status_t ST_ACTIVE    = 3'd3;
    localparam status_t ST_DETECTED  = 3'd4;
    localparam status_t ST_CLEARED   = 3'd5;

    // Configuration register indexes
    localparam cfg_idx_t CFG_DETECT_THR  = 3'd0;
    localparam cfg_idx_t CFG_CLEAR_THR   = 3'd1;
    localparam cfg_idx_t CFG_HITS_REQ    = 3'd2;
    localparam cfg_idx_t CFG_CLEARS_REQ  = 3'd3;
    localparam cfg_idx_t CFG_COOLDOWN_S  = 3'd4;

    // Configuration reset values
    localparam logic [SCORE_W-1:0] DETECT_THR_RESET = 16'd49152;
    localparam logic [SCORE_W-1:0] CLEAR_THR_RESET  = 16'd29491;
    localparam logic [REQ_W-1:0]   HITS_REQ_RESET   = 4'd8;
    localparam logic [REQ_W-1:0]   CLEARS_REQ_RESET = 4'd8;
    localparam logic [15:0]        COOLDOWN_RESET   = 16'd300;

    // One vote: hit mark and clear mark
    typedef struct packed {
        logic clr;
        logic hit;
    } vote_t;

    // Window control for the current cycle
    typedef struct packed {
        logic shift;
        logic flush;
    } chain_ctrl_t;

endpackage

>>> design/whvd_in_if.sv
// ---------------------------------------------------------------------------
// whvd_in_if
// Input item channel: valid/ready handshake with the item fields.
// ---------------------------------------------------------------------------
interface whvd_in_if;

    logic        valid;
    logic        ready;
    logic        monitor_enable;
    logic [15:0] score;
    logic [39:0] time_ms;

    modport source (
        output valid,
        output monitor_enable,
        output score,
        output time_ms,
        input  ready
    );

    modport sink (
        input  valid,
        input  monitor_enable,
        input  score,
        input  time_ms,
        output ready
    );

endinterface

>>> design/whvd_out_if.sv
// ---------------------------------------------------------------------------
// whvd_out_if
// Result channel: valid/ready handshake with the result fields.
// ---------------------------------------------------------------------------
interface whvd_out_if;

    logic       valid;
    logic       ready;
    logic [2:0] status;
    logic       adjust_request;
    logic       cooldown_hold;
    logic       release_request;
    logic [3:0] hit_votes;
    logic [3:0] clear_votes;
    logic [3:0] window_fill;
    logic       monitor_started;
    logic       monitor_paused;

    modport source (
        output valid,
        output status,
        output adjust_request,
        output cooldown_hold,
        output release_request,
        output hit_votes,
        output clear_votes,
        output window_fill,
        output monitor_started,
        output monitor_paused,
        input  ready
    );

    modport sink (
        input  valid,
        input  status,
        input  adjust_request,
        input  cooldown_hold,
        input  release_request,
        input  hit_votes,
        input  clear_votes,
        input  window_fill,
        input  monitor_started,
        input  monitor_paused,
        output ready
    );

endinterface

>>> design/windowed_vote_hysteresis_detector.sv
// ---------------------------------------------------------------------------
// windowed_vote_hysteresis_detector
// k-of-n sliding vote window with hysteresis and an adjustment cooldown.
// ---------------------------------------------------------------------------
// A result beat is valid in the cycle after its item beat is accepted.
// Throughput: one item per cycle; the window, counts and detect state update in
// the accept cycle. A new item enters in the cycle the waiting result beat is
// taken, so a stalled result stalls the input for as long as it waits.
// Reset clears the window, counts, detect, monitoring and cooldown state and
// loads the configuration registers with their defaults.
module windowed_vote_hysteresis_detector #(
    parameter int WINDOW = 10
) (
    input  logic                            clk,
    input  logic                            rst_n,
    whvd_in_if.sink                         item,
    whvd_out_if.source                      result,
    input  logic                            cfg_write_en,
    input  whvd_pkg::cfg_idx_t              cfg_index,
    input  logic [whvd_pkg::CFG_DATA_W-1:0] cfg_data
);
    import whvd_pkg::*;

    `include "assert_macros.svh"

    localparam int CNT_W = $clog2(WINDOW + 1);

    // ---------------------------------------------------------------
    // Configuration registers
    // ---------------------------------------------------------------
    logic [SCORE_W-1:0] detect_thr_reg;
    logic [SCORE_W-1:0] clear_thr_reg;
    logic [REQ_W-1:0]   hits_req_reg;
    logic [REQ_W-1:0]   clears_req_reg;
    logic [15:0]        cooldown_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            detect_thr_reg <= DETECT_THR_RESET;
            clear_thr_reg  <= CLEAR_THR_RESET;
            hits_req_reg   <= HITS_REQ_RESET;
            clears_req_reg <= CLEARS_REQ_RESET;
            cooldown_reg   <= COOLDOWN_RESET;
        end
        else if (cfg_write_en)
        begin
            unique case (cfg_index)
                CFG_DETECT_THR:  detect_thr_reg <= cfg_data;
                CFG_CLEAR_THR:   clear_thr_reg  <= cfg_data;
                CFG_HITS_REQ:    hits_req_reg   <= cfg_data[REQ_W-1:0];
                CFG_CLEARS_REQ:  clears_req_reg <= cfg_data[REQ_W-1:0];
                CFG_COOLDOWN_S:  cooldown_reg   <= cfg_data;
                default:         ; // drop writes to unmapped indexes
            endcase
        end
    end

    // ---------------------------------------------------------------
    // Detector state
    // ---------------------------------------------------------------
    logic [CNT_W-1:0]  fill_reg,  fill_next;
    logic [CNT_W-1:0]  hits_reg,  hits_next;
    logic [CNT_W-1:0]  clears_reg, clears_next;
    logic              detect_reg, detect_next;
    logic              monitoring_reg, monitoring_next;
    logic              ever_adj_reg, ever_adj_next;
    logic [TIME_W-1:0] last_adj_reg, last_adj_next;

    // Result register
    logic              out_valid_reg, out_valid_next;
    status_t           status_reg, status_next;
    logic              adjust_reg, adjust_next;
    logic              hold_reg, hold_next;
    logic              release_reg, release_next;
    logic              started_reg, started_next;
    logic              paused_reg, paused_next;

    // ---------------------------------------------------------------
    // Handshake: take a new item whenever the result register frees up
    // ---------------------------------------------------------------
    logic accept;
    assign item.ready = ~out_valid_reg | result.ready;
    assign accept     = item.valid & item.ready;

    // ---------------------------------------------------------------
    // Vote window
    // ---------------------------------------------------------------
    chain_ctrl_t ctrl;
    vote_t       new_vote;
    vote_t       drop_vote;

    whvd_chain #(
        .WINDOW (WINDOW)
    ) u_chain (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctrl      (ctrl),
        .head_vote (new_vote),
        .drop_vote (drop_vote)
    );

    // ---------------------------------------------------------------
    // Count update, hysteresis and cooldown
    // ---------------------------------------------------------------
    logic              enable;
    logic              starting;
    logic              pausing;
    logic [CNT_W-1:0]  base_fill;
    logic [CNT_W-1:0]  base_hits;
    logic [CNT_W-1:0]  base_clears;
    logic              base_detect;
    vote_t             drop;
    logic [CNT_W-1:0]  push_fill;
    logic [CNT_W-1:0]  push_hits;
    logic [CNT_W-1:0]  push_clears;
    logic              full;
    logic              meets_hits;
    logic              meets_clears;
    logic              just_det;
    logic              just_clr;
    logic [TIME_W-1:0] elapsed;
    logic [TIME_W-1:0] cool_ext;
    logic [TIME_W-1:0] cool_need;
    logic              cool_ok;

    always_comb
    begin
        enable   = item.monitor_enable;
        starting = enable & ~monitoring_reg;
        pausing  = ~enable & monitoring_reg;

        new_vote.hit = (item.score >= detect_thr_reg);
        new_vote.clr = (item.score <  clear_thr_reg);

        // A monitor start sees an empty window
        base_fill   = starting ? '0 : fill_reg;
        base_hits   = starting ? '0 : hits_reg;
        base_clears = starting ? '0 : clears_reg;
        base_detect = starting ? 1'b0 : detect_reg;
        drop        = starting ? '0 : drop_vote;

        push_fill   = (base_fill == CNT_W'(WINDOW)) ? base_fill : base_fill + CNT_W'(1);
        push_hits   = base_hits - CNT_W'(drop.hit) + CNT_W'(new_vote.hit);
        push_clears = base_clears - CNT_W'(drop.clr) + CNT_W'(new_vote.clr);

        full         = (push_fill == CNT_W'(WINDOW));
        meets_hits   = {{REQ_W{1'b0}}, push_hits} >= {{CNT_W{1'b0}}, hits_req_reg};
        meets_clears = {{REQ_W{1'b0}}, push_clears} >= {{CNT_W{1'b0}}, clears_req_reg};
        just_det     = ~base_detect & full & meets_hits;
        just_clr     =  base_detect & full & meets_clears;

        // Cooldown in ms: seconds * 1000 = s*1024 - s*16 - s*8, timestamp wraps
        cool_ext  = TIME_W'(cooldown_reg);
        cool_need = (cool_ext << 10) - (cool_ext << 4) - (cool_ext << 3);
        elapsed   = item.time_ms - last_adj_reg;
        cool_ok   = ~ever_adj_reg | (elapsed >= cool_need);

        // Hold state unless an item is accepted
        fill_next       = fill_reg;
        hits_next       = hits_reg;
        clears_next     = clears_reg;
        detect_next     = detect_reg;
        monitoring_next = monitoring_reg;
        ever_adj_next   = ever_adj_reg;
        last_adj_next   = last_adj_reg;

        status_next  = status_reg;
        adjust_next  = adjust_reg;
        hold_next    = hold_reg;
        release_next = release_reg;
        started_next = started_reg;
        paused_next  = paused_reg;

        ctrl.shift = accept & enable;
        ctrl.flush = accept & (starting | pausing);

        if (accept)
        begin
            monitoring_next = enable;
            started_next    = starting;
            paused_next     = pausing;
            adjust_next     = 1'b0;
            hold_next       = 1'b0;
            release_next    = 1'b0;

            if (!enable)
            begin
                // Pause: drop every vote and the detect state
                fill_next   = '0;
                hits_next   = '0;
                clears_next = '0;
                detect_next = 1'b0;
                status_next = ST_PAUSED;
            end
            else
            begin
                fill_next   = push_fill;
                hits_next   = push_hits;
                clears_next = push_clears;

                priority if (just_det)
                begin
                    detect_next = 1'b1;
                    status_next = ST_DETECTED;
                    adjust_next = cool_ok;
                    hold_next   = ~cool_ok;
                    if (cool_ok)
                    begin
                        ever_adj_next = 1'b1;
                        last_adj_next = item.time_ms;
                    end
                end
                else if (just_clr)
                begin
                    detect_next  = 1'b0;
                    status_next  = ST_CLEARED;
                    release_next = 1'b1;
                end
                else
                begin
                    detect_next = base_detect;
                    if (base_detect)
                        status_next = ST_ACTIVE;
                    else if (push_hits != '0)
                        status_next = ST_CANDIDATE;
                    else
                        status_next = ST_QUIET;
                end
            end
        end

        // Result register: load on accept, drop once taken
        if (accept)
            out_valid_next = 1'b1;
        else if (result.ready)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fill_reg       <= '0;
            hits_reg       <= '0;
            clears_reg     <= '0;
            detect_reg     <= 1'b0;
            monitoring_reg <= 1'b0;
            ever_adj_reg   <= 1'b0;
            last_adj_reg   <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            fill_reg       <= fill_next;
            hits_reg       <= hits_next;
            clears_reg     <= clears_next;
            detect_reg     <= detect_next;
            monitoring_reg <= monitoring_next;
            ever_adj_reg   <= ever_adj_next;
            last_adj_reg   <= last_adj_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    // Result payload needs no reset
    always_ff @(posedge clk)
    begin
        status_reg  <= status_next;
        adjust_reg  <= adjust_next;
        hold_reg    <= hold_next;
        release_reg <= release_next;
        started_reg <= started_next;
        paused_reg  <= paused_next;
    end

    // ---------------------------------------------------------------
    // Result beat; counts come from the state, which moves only with
    // the next accept, so they stay matched to the waiting beat
    // ---------------------------------------------------------------
    assign result.valid           = out_valid_reg;
    assign result.status          = status_reg;
    assign result.adjust_request  = adjust_reg;
    assign result.cooldown_hold   = hold_reg;
    assign result.release_request = release_reg;
    assign result.hit_votes   = COUNT_OUT_W'({{COUNT_OUT_W{1'b0}}, hits_reg});
    assign result.clear_votes = COUNT_OUT_W'({{COUNT_OUT_W{1'b0}}, clears_reg});
    assign result.window_fill = COUNT_OUT_W'({{COUNT_OUT_W{1'b0}}, fill_reg});
    assign result.monitor_started = started_reg;
    assign result.monitor_paused  = paused_reg;

    // ---------------------------------------------------------------
    // Assertions
    // ---------------------------------------------------------------
    `ASSERT_ALWAYS(a_fill_bound, clk, rst_n, fill_reg <= CNT_W'(WINDOW), "window fill above depth")
    `ASSERT_ALWAYS(a_counts_bound, clk, rst_n, (hits_reg <= fill_reg) && (clears_reg <= fill_reg), "vote count above fill")
    `ASSERT_ALWAYS(a_idle_empty, clk, rst_n, monitoring_reg || ((fill_reg == '0) && !detect_reg), "votes held while paused")
    `ASSERT_ALWAYS(a_adjust_on_detect, clk, rst_n, !(out_valid_reg && adjust_reg) || (status_reg == ST_DETECTED), "adjust request without detection")
    `ASSERT_NEXT(a_adjust_stamps, clk, rst_n, accept && enable && just_det && cool_ok, ever_adj_reg && (last_adj_reg == $past(item.time_ms)), "adjust time not recorded")

endmodule

>>> design/whvd_cell.sv
// ---------------------------------------------------------------------------
// whvd_cell
// One window slot: holds a vote and its valid bit, shifts on command.
// ---------------------------------------------------------------------------
module whvd_cell (
    input  logic                  clk,
    input  logic                  rst_n,
    input  whvd_pkg::chain_ctrl_t ctrl,
    input  logic                  in_valid,
    input  whvd_pkg::vote_t       in_vote,
    output logic                  valid,
    output whvd_pkg::vote_t       vote
);
    import whvd_pkg::*;

    logic  valid_reg;
    logic  valid_next;
    vote_t vote_reg;
    vote_t vote_next;

    always_comb
    begin
        valid_next = valid_reg;
        vote_next  = vote_reg;
        if (ctrl.shift)
        begin
            valid_next = in_valid;
            vote_next  = in_vote;
        end
        else if (ctrl.flush)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        vote_reg <= vote_next;
    end

    // An empty slot reads as no vote
    assign valid = valid_reg;
    assign vote  = valid_reg ? vote_reg : '0;

endmodule

>>> design/whvd_chain.sv
// ---------------------------------------------------------------------------
// whvd_chain
// Vote window as a row of cells; the oldest vote falls out of the tail.
// ---------------------------------------------------------------------------
module whvd_chain #(
    parameter int WINDOW = 10
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  whvd_pkg::chain_ctrl_t ctrl,
    input  whvd_pkg::vote_t       head_vote,
    output whvd_pkg::vote_t       drop_vote
);
    import whvd_pkg::*;

    logic  cell_valid [WINDOW];
    vote_t cell_vote  [WINDOW];

    genvar i;
    generate
        for (i = 0; i < WINDOW; i++)
        begin : g_cell
            logic  link_valid;
            vote_t link_vote;

            if (i == 0)
            begin : g_head
                assign link_valid = 1'b1;
                assign link_vote  = head_vote;
            end
            else
            begin : g_body
                // A flush together with a shift leaves only the head valid
                assign link_valid = cell_valid[i-1] & ~ctrl.flush;
                assign link_vote  = cell_vote[i-1];
            end

            whvd_cell u_cell (
                .clk      (clk),
                .rst_n    (rst_n),
                .ctrl     (ctrl),
                .in_valid (link_valid),
                .in_vote  (link_vote),
                .valid    (cell_valid[i]),
                .vote     (cell_vote[i])
            );
        end
    endgenerate

    // Tail slot is valid only once the window is full
    assign drop_vote = cell_vote[WINDOW-1];

endmodule
